>>> rtl/gif_lzw_pixel_decoder_assert.svh
// Assertion macros shared by the checker of the GIF LZW pixel decoder.
// Each macro expands to one labelled concurrent assertion clocked on clk
// and switched off while rst_n is low.
`ifndef GIF_LZW_PIXEL_DECODER_ASSERT_SVH
`define GIF_LZW_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication.
`define GLPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/glpd_pkg.sv
// ----------------------------------------------------------------------------
// glpd_pkg
// Shared types, codes and constants of the GIF LZW pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package glpd_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int CODE_W            = 12;

  localparam logic [3:0]  ROOT_RST = 4'd8;
  localparam logic [14:0] LINE_RST = 15'd640;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_ROOT      = 2'd0;
  localparam logic [1:0] REG_LINE      = 2'd1;
  localparam logic [1:0] REG_SKIP_COLS = 2'd2;
  localparam logic [1:0] REG_SKIP_ROWS = 2'd3;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_NEED    = 3'd1,
    ST_ENDED   = 3'd2,
    ST_TAKEN   = 3'd3,
    ST_REFUSED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [3:0]  root_code_size;
    logic [14:0] line_width;
    logic [7:0]  skip_columns;
    logic [7:0]  skip_rows;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  pixel;
    logic        pixel_kept;
    logic        row_end;
    logic [15:0] bad_codes;
  } result_t;

  // Minimum code size saturated into 2..9.
  function automatic logic [3:0] root_used(input logic [3:0] root);
    logic [3:0] r;
    begin
      if (root < 4'd2) r = 4'd2;
      else if (root > 4'd9) r = 4'd9;
      else r = root;
      return r;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/glpd_ram.sv
// ----------------------------------------------------------------------------
// glpd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module glpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/glpd_regs.sv
// ----------------------------------------------------------------------------
// glpd_regs
// APB-style configuration registers of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module glpd_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output glpd_pkg::cfg_t     cfg
);
  import glpd_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.root_code_size <= ROOT_RST;
      cfg_r.line_width     <= LINE_RST;
      cfg_r.skip_columns   <= 8'd0;
      cfg_r.skip_rows      <= 8'd0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ROOT:      cfg_r.root_code_size <= pwdata[3:0];
        REG_LINE:      cfg_r.line_width     <= pwdata[14:0];
        REG_SKIP_COLS: cfg_r.skip_columns   <= pwdata[7:0];
        REG_SKIP_ROWS: cfg_r.skip_rows      <= pwdata[7:0];
        default:       cfg_r.skip_rows      <= cfg_r.skip_rows;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROOT:      prdata = {28'd0, cfg_r.root_code_size};
      REG_LINE:      prdata = {17'd0, cfg_r.line_width};
      REG_SKIP_COLS: prdata = {24'd0, cfg_r.skip_columns};
      REG_SKIP_ROWS: prdata = {24'd0, cfg_r.skip_rows};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/glpd_engine.sv
// ----------------------------------------------------------------------------
// glpd_engine
// Code unpacking, string table walk, pixel stack and row/column marking.
// ----------------------------------------------------------------------------
`default_nettype none

module glpd_engine #(
  parameter int TABLE_ENTRIES = glpd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = glpd_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire glpd_pkg::cmd_t                   cmd,
  input  wire logic [7:0]                       data_byte,
  input  wire glpd_pkg::cfg_t                   cfg,
  output logic                                  idle,
  output logic                                  res_valid,
  output glpd_pkg::result_t                     res,
  output logic                                  tbl_we,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      tbl_waddr,
  output logic [glpd_pkg::CODE_W+7:0]           tbl_wdata,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      tbl_raddr,
  input  wire logic [glpd_pkg::CODE_W+7:0]      tbl_rdata,
  output logic                                  stk_we,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      stk_waddr,
  output logic [7:0]                            stk_wdata,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      stk_raddr,
  input  wire logic [7:0]                       stk_rdata
);
  import glpd_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int DW = AW + 1;
  localparam logic [DW-1:0] DEPTH_MAX = DW'(TABLE_ENTRIES);
  localparam logic [12:0]   ENTRIES13 = 13'(TABLE_ENTRIES);
  localparam logic [3:0]    CW_MAX    = 4'(MAX_CODE_BITS);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_PULL    = 5'b00010,
    S_WALK    = 5'b00100,
    S_WALK_RD = 5'b01000,
    S_POP     = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [23:0]       resv_r, resv_nxt;
  logic [4:0]        held_r, held_nxt;
  logic [3:0]        cw_r, cw_nxt;
  logic [12:0]       limit_r, limit_nxt;
  logic [12:0]       next_r, next_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic [14:0]       colc_r, colc_nxt;
  logic [8:0]        cskip_r, cskip_nxt;
  logic [8:0]        rskip_r, rskip_nxt;
  logic              aclr_r, aclr_nxt;
  logic              ended_r, ended_nxt;
  logic [15:0]       tally_r, tally_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CODE_W-1:0] cin_r, cin_nxt;
  logic [DW-1:0]     steps_r, steps_nxt;

  logic [3:0]        root;
  logic [12:0]       clear_code;
  logic [12:0]       end_code;
  logic [12:0]       base_code;
  logic [23:0]       width_mask;
  logic [CODE_W-1:0] code_in;
  logic [12:0]       code_in13;
  logic [CODE_W-1:0] start_code;
  logic              row_kept;

  assign root       = root_used(cfg.root_code_size);
  assign clear_code = 13'd1 << root;
  assign end_code   = clear_code + 13'd1;
  assign base_code  = clear_code + 13'd2;
  assign width_mask = (24'd1 << cw_r) - 24'd1;
  assign code_in    = CODE_W'(resv_r & width_mask);
  assign code_in13  = {1'b0, code_in};
  assign row_kept   = (rskip_r == 9'd0);
  assign idle       = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    resv_nxt   = resv_r;
    held_nxt   = held_r;
    cw_nxt     = cw_r;
    limit_nxt  = limit_r;
    next_nxt   = next_r;
    prev_nxt   = prev_r;
    first_nxt  = first_r;
    depth_nxt  = depth_r;
    colc_nxt   = colc_r;
    cskip_nxt  = cskip_r;
    rskip_nxt  = rskip_r;
    aclr_nxt   = aclr_r;
    ended_nxt  = ended_r;
    tally_nxt  = tally_r;
    code_nxt   = code_r;
    cin_nxt    = cin_r;
    steps_nxt  = steps_r;
    start_code = code_in;

    res_valid      = 1'b0;
    res.status     = ST_NEED;
    res.pixel      = 8'd0;
    res.pixel_kept = 1'b0;
    res.row_end    = 1'b0;

    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '0;
    tbl_raddr = code_r[AW-1:0];
    stk_we    = 1'b0;
    stk_waddr = depth_r[AW-1:0];
    stk_wdata = 8'd0;
    stk_raddr = AW'(depth_r - DW'(1));

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (cmd)
            CMD_BYTE: begin
              res_valid = 1'b1;
              if (!ended_r && held_r <= 5'd16) begin
                resv_nxt   = resv_r | (24'(data_byte) << held_r);
                held_nxt   = held_r + 5'd8;
                res.status = ST_TAKEN;
              end else begin
                res.status = ST_REFUSED;
              end
            end
            CMD_PULL: state_nxt = S_PULL;
            CMD_START: begin
              res_valid  = 1'b1;
              res.status = ST_NEED;
              resv_nxt   = 24'd0;
              held_nxt   = 5'd0;
              cw_nxt     = root + 4'd1;
              limit_nxt  = 13'd1 << (root + 4'd1);
              next_nxt   = base_code;
              prev_nxt   = '0;
              first_nxt  = 8'd0;
              depth_nxt  = '0;
              colc_nxt   = cfg.line_width;
              cskip_nxt  = 9'd0;
              rskip_nxt  = 9'd0;
              aclr_nxt   = 1'b0;
              ended_nxt  = 1'b0;
              tally_nxt  = 16'd0;
            end
            CMD_NONE: begin
              res_valid  = 1'b1;
              res.status = ST_REFUSED;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_PULL: begin
        priority if (ended_r) begin
          res_valid  = 1'b1;
          res.status = ST_ENDED;
          state_nxt  = S_IDLE;
        end else if (depth_r != '0) begin
          // Stack read issued here, pixel leaves in the next cycle.
          state_nxt = S_POP;
        end else if (held_r < {1'b0, cw_r}) begin
          res_valid  = 1'b1;
          res.status = ST_NEED;
          state_nxt  = S_IDLE;
        end else begin
          resv_nxt = resv_r >> cw_r;
          held_nxt = held_r - {1'b0, cw_r};
          priority if (code_in13 == end_code) begin
            ended_nxt = 1'b1;
          end else if (code_in13 == clear_code) begin
            cw_nxt    = root + 4'd1;
            limit_nxt = 13'd1 << (root + 4'd1);
            next_nxt  = base_code;
            aclr_nxt  = 1'b1;
          end else if (aclr_r) begin
            if (code_in13 >= next_r) start_code = '0;
            prev_nxt  = start_code;
            first_nxt = start_code[7:0];
            stk_we    = 1'b1;
            stk_wdata = start_code[7:0];
            depth_nxt = depth_r + DW'(1);
            aclr_nxt  = 1'b0;
          end else begin
            cin_nxt   = code_in;
            code_nxt  = code_in;
            steps_nxt = '0;
            if (code_in13 >= next_r) begin
              if (code_in13 > next_r) begin
                if (tally_r != 16'hFFFF) tally_nxt = tally_r + 16'd1;
                cin_nxt = next_r[CODE_W-1:0];
              end
              code_nxt  = prev_r;
              stk_we    = 1'b1;
              stk_wdata = first_r;
              depth_nxt = depth_r + DW'(1);
            end
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if ({1'b0, code_r} >= base_code && steps_r < DEPTH_MAX) begin
          if ({1'b0, code_r} < ENTRIES13) begin
            state_nxt = S_WALK_RD;
          end else begin
            code_nxt  = '0;
            steps_nxt = steps_r + DW'(1);
          end
        end else begin
          if (depth_r < DEPTH_MAX) begin
            stk_we    = 1'b1;
            stk_wdata = code_r[7:0];
            depth_nxt = depth_r + DW'(1);
          end
          if (next_r < limit_r) begin
            if (next_r < ENTRIES13) begin
              tbl_we    = 1'b1;
              tbl_waddr = next_r[AW-1:0];
              tbl_wdata = {prev_r, code_r[7:0]};
            end
            first_nxt = code_r[7:0];
            next_nxt  = next_r + 13'd1;
            prev_nxt  = cin_r;
          end
          if (next_nxt >= limit_r && cw_r < CW_MAX) begin
            limit_nxt = limit_r << 1;
            cw_nxt    = cw_r + 4'd1;
          end
          state_nxt = S_PULL;
        end
      end

      S_WALK_RD: begin
        if (depth_r < DEPTH_MAX) begin
          stk_we    = 1'b1;
          stk_wdata = tbl_rdata[7:0];
          depth_nxt = depth_r + DW'(1);
        end
        code_nxt  = tbl_rdata[CODE_W+7:8];
        steps_nxt = steps_r + DW'(1);
        state_nxt = S_WALK;
      end

      S_POP: begin
        res_valid  = 1'b1;
        res.status = ST_PIXEL;
        res.pixel  = stk_rdata;
        depth_nxt  = depth_r - DW'(1);
        if (cskip_r == 9'd0) begin
          res.pixel_kept = row_kept;
          cskip_nxt      = {1'b0, cfg.skip_columns};
        end else begin
          cskip_nxt = cskip_r - 9'd1;
        end
        if (colc_r <= 15'd1) begin
          res.row_end = 1'b1;
          rskip_nxt   = row_kept ? {1'b0, cfg.skip_rows} : rskip_r - 9'd1;
          colc_nxt    = cfg.line_width;
          cskip_nxt   = 9'd0;
        end else begin
          colc_nxt = colc_r - 15'd1;
        end
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    res.bad_codes = tally_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resv_r  <= 24'd0;
      held_r  <= 5'd0;
      cw_r    <= ROOT_RST + 4'd1;
      limit_r <= 13'd1 << (ROOT_RST + 4'd1);
      next_r  <= (13'd1 << ROOT_RST) + 13'd2;
      prev_r  <= '0;
      first_r <= 8'd0;
      depth_r <= '0;
      colc_r  <= LINE_RST;
      cskip_r <= 9'd0;
      rskip_r <= 9'd0;
      aclr_r  <= 1'b0;
      ended_r <= 1'b0;
      tally_r <= 16'd0;
    end else begin
      state_r <= state_nxt;
      resv_r  <= resv_nxt;
      held_r  <= held_nxt;
      cw_r    <= cw_nxt;
      limit_r <= limit_nxt;
      next_r  <= next_nxt;
      prev_r  <= prev_nxt;
      first_r <= first_nxt;
      depth_r <= depth_nxt;
      colc_r  <= colc_nxt;
      cskip_r <= cskip_nxt;
      rskip_r <= rskip_nxt;
      aclr_r  <= aclr_nxt;
      ended_r <= ended_nxt;
      tally_r <= tally_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    cin_r   <= cin_nxt;
    steps_r <= steps_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/gif_lzw_pixel_decoder.sv
// ----------------------------------------------------------------------------
// gif_lzw_pixel_decoder
// GIF LZW decoder: takes compressed bytes and answers pulls with pixels.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Word
//   in_*      input      in_valid / in_stall  cmd, data_byte
//   out_*     output     out_valid/out_stall  status, pixel, kept, row end, tally
//   cfg (APB) input      psel/penable/pready  four registers at 0x0..0xC
//
// A byte, start or unused command is answered straight from the idle state. A
// pull that finds pixels on the stack goes through a stack read, a pop and the
// return. A clear code, the end code or the first code after a clear is dealt
// with in the pull state alone; any other code also walks the prefix chain,
// each link being a read of the string table RAM followed by a push.
// Reset is synchronous and active low; the RAMs are not cleared. One word is
// in flight at a time: in_stall is high from acceptance until the result has
// left the output register, so a stalled result holds the input side too.
//
`default_nettype none

module gif_lzw_pixel_decoder #(
  parameter int TABLE_ENTRIES = glpd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = glpd_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [7:0]       out_pixel,
  output logic             out_pixel_kept,
  output logic             out_row_end,
  output logic [15:0]      out_bad_codes,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import glpd_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);

  cfg_t    cfg;
  logic    eng_idle;
  logic    eng_start;
  logic    res_valid;
  result_t res;
  result_t out_r;
  logic    out_valid_r;

  logic              tbl_we;
  logic [AW-1:0]     tbl_waddr;
  logic [CODE_W+7:0] tbl_wdata;
  logic [AW-1:0]     tbl_raddr;
  logic [CODE_W+7:0] tbl_rdata;
  logic              stk_we;
  logic [AW-1:0]     stk_waddr;
  logic [7:0]        stk_wdata;
  logic [AW-1:0]     stk_raddr;
  logic [7:0]        stk_rdata;

  assign pready = 1'b1;

  // A word is taken only when the engine is idle and the result slot is free.
  assign in_stall  = !(eng_idle && !out_valid_r);
  assign eng_start = in_valid && !in_stall;

  glpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  glpd_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (eng_start),
    .cmd       (cmd_t'(in_cmd)),
    .data_byte (in_data_byte),
    .cfg       (cfg),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata),
    .stk_we    (stk_we),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata)
  );

  // String table: prefix code in the upper bits, suffix byte in the lower.
  glpd_ram #(
    .WIDTH (CODE_W + 8),
    .DEPTH (TABLE_ENTRIES)
  ) u_table_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Pixel stack: a string is pushed last character first and popped in order.
  glpd_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_ENTRIES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Output register. The engine only finishes a word while this is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_pixel      = out_r.pixel;
  assign out_pixel_kept = out_r.pixel_kept;
  assign out_row_end    = out_r.row_end;
  assign out_bad_codes  = out_r.bad_codes;

endmodule

`default_nettype wire

>>> rtl/glpd_checker.sv
// ----------------------------------------------------------------------------
// glpd_checker
// Port-level assertions for the GIF LZW pixel decoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gif_lzw_pixel_decoder_assert.svh"

module glpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [7:0]  out_pixel,
  input wire logic        out_pixel_kept,
  input wire logic        out_row_end
);
  import glpd_pkg::*;

  // Only one word is in flight, so an accepted word closes the input side.
  `GLPD_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second word taken while busy")

  // A result leaves and is never followed at once by another.
  `GLPD_ASSERT_NEXT(a_single_result, out_valid && !out_stall, !out_valid, "result repeated")

  // A stalled result holds its pixel.
  `GLPD_ASSERT_NEXT(a_hold_pixel, out_valid && out_stall, out_valid && $stable(out_pixel), "stalled result changed")

  // Pixel fields are clear unless the word carries a pixel.
  `GLPD_ASSERT_NOW(a_no_pixel_fields, out_valid && out_status != ST_PIXEL, out_pixel == 8'd0 && !out_pixel_kept && !out_row_end, "pixel fields set without a pixel")

endmodule

bind gif_lzw_pixel_decoder glpd_checker u_glpd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_pixel      (out_pixel),
  .out_pixel_kept (out_pixel_kept),
  .out_row_end    (out_row_end)
);

`default_nettype wire
